// ===== src/pmc_pkg.sv =====
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int MAX_DEGREE_DEF = 6;
  localparam int COEF_WIDTH_DEF = 16;

  // register map: coefficient registers 0..6, then the degree register
  localparam int NUM_COEF_REGS = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int DEG_REG_W     = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd7;

  typedef struct packed {
    logic load;      // capture a new product
    logic step;      // advance the accumulator
    logic use_prod;  // add the product, otherwise shift only
    logic clear;     // load zero into the accumulator
  } cell_ctrl_t;

endpackage

// ===== src/pmc_cell.sv =====
`timescale 1ns / 1ps

module pmc_cell import pmc_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int ACC_W      = 2 * COEF_WIDTH + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctrl_t                   ctrl_i,
  input  logic signed [COEF_WIDTH-1:0] coef_i,
  input  logic signed [COEF_WIDTH-1:0] x_i,
  input  logic signed [ACC_W-1:0]      sum_i,
  output logic signed [ACC_W-1:0]      acc_o
);

  localparam int PROD_W = 2 * COEF_WIDTH;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;

  assign prod_d = coef_i * x_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.use_prod) begin
      acc_d = ACC_W'(prod_q) + sum_i;
    end else begin
      acc_d = sum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== src/polynomial_multiply_convolve.sv =====
`timescale 1ns / 1ps

// Streaming polynomial multiplier, transposed convolution chain.
// The fixed polynomial A is written through the cfg port (coef 0..6 at
// indices 0..6, degree at index 7); the user must write it only while the
// block is idle, and the block itself does not enforce this. Coefficients
// of B enter on the s_axis channel, lowest degree first, tlast on the
// highest. Each s_axis transaction gives one product coefficient on m_axis;
// the one marked tlast also gives degree further tail coefficients, the
// final one with tlast, after which the running sums are cleared.
// A result is registered first in the product register of each cell, loaded
// when its input is accepted, then in the accumulator chain, whose first
// cell doubles as the output register.
// Throughput: one transaction per cycle while m_axis is ready and no tail is
// being shifted out; after a tlast transaction the chain shifts out the
// tail, during which one further input may wait in the product stage.
// Reset clears the configuration and control registers, the running sums and
// all valid flags; the product registers are not reset. A stall on
// m_axis_tready holds the output and the whole chain; s_axis_tready then drops once the product stage is occupied.
module polynomial_multiply_convolve import pmc_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // in_coef
  input  logic [((COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // in_last
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_coef
  output logic [((2*COEF_WIDTH+3+7)/8)*8-1:0] m_axis_tdata,
  // out_last
  output logic                 m_axis_tlast
);

  localparam int SUM_W      = 2 * COEF_WIDTH + 2;
  localparam int OUT_W      = 2 * COEF_WIDTH + 3;
  localparam int OUT_TD_W   = ((OUT_W + 7) / 8) * 8;
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);

  // configuration
  logic signed [COEF_WIDTH-1:0] coef_q [0:MAX_DEGREE];
  logic [DEG_REG_W-1:0]         deg_q;
  logic [DEG_W-1:0]             eff_deg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == REG_DEGREE) begin
      deg_q <= cfg_data_i[DEG_REG_W-1:0];
    end
  end

  for (genvar k = 0; k <= MAX_DEGREE; k++) begin : g_coef
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_q[k] <= '0;
      end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(k)) begin
        coef_q[k] <= cfg_data_i;
      end
    end
  end

  assign eff_deg = (deg_q > DEG_REG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                    : deg_q[DEG_W-1:0];

  // control
  logic             m_valid_q, m_valid_d;
  logic             m_last_q;
  logic [DEG_W-1:0] m_deg_q;
  logic [DEG_W-1:0] flush_cnt_q, flush_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic             adv, flushing, a_fire, m_take, s_fire, fin;
  cell_ctrl_t       ctrl;
  cell_ctrl_t       ctrl0;

  assign adv      = !out_valid_q || m_axis_tready;
  assign flushing = (flush_cnt_q != '0);
  assign a_fire   = adv && (flushing || m_valid_q);
  assign m_take   = adv && !flushing && m_valid_q;
  assign s_axis_tready = !m_valid_q || m_take;
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // final result of a frame: end of the tail, or a degree-zero last item
  assign fin = flushing ? (flush_cnt_q == DEG_W'(1)) : (m_last_q && m_deg_q == '0);

  assign ctrl.load     = s_fire;
  assign ctrl.step     = a_fire;
  assign ctrl.use_prod = !flushing;
  assign ctrl.clear    = a_fire && fin;

  // the first cell is the output register and is never cleared
  always_comb begin
    ctrl0       = ctrl;
    ctrl0.clear = 1'b0;
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (s_fire) begin
      m_valid_d = 1'b1;
    end else if (m_take) begin
      m_valid_d = 1'b0;
    end
  end

  always_comb begin
    flush_cnt_d = flush_cnt_q;
    if (a_fire) begin
      if (flushing) begin
        flush_cnt_d = flush_cnt_q - DEG_W'(1);
      end else if (m_last_q) begin
        flush_cnt_d = m_deg_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    if (a_fire) begin
      out_valid_d = 1'b1;
      out_last_d  = fin;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      m_last_q    <= 1'b0;
      m_deg_q     <= '0;
      flush_cnt_q <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      m_valid_q   <= m_valid_d;
      flush_cnt_q <= flush_cnt_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      if (s_fire) begin
        m_last_q <= s_axis_tlast;
        m_deg_q  <= eff_deg;
      end
    end
  end

  // chain of cells
  logic signed [COEF_WIDTH-1:0] x_in;
  logic signed [COEF_WIDTH-1:0] coef_eff [0:MAX_DEGREE];
  logic signed [SUM_W-1:0]      ps     [1:MAX_DEGREE + 1];
  logic signed [OUT_W-1:0]      y_q;

  assign x_in = s_axis_tdata[COEF_WIDTH-1:0];
  assign ps[MAX_DEGREE + 1] = '0;

  for (genvar k = 0; k <= MAX_DEGREE; k++) begin : g_chain
    if (k == 0) begin : g_head
      assign coef_eff[k] = coef_q[k];
      pmc_cell #(
        .COEF_WIDTH(COEF_WIDTH),
        .ACC_W     (OUT_W)
      ) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctrl_i(ctrl0),
        .coef_i(coef_eff[k]),
        .x_i   (x_in),
        .sum_i (OUT_W'(ps[1])),
        .acc_o (y_q)
      );
    end else begin : g_body
      assign coef_eff[k] = (DEG_W'(k) <= eff_deg) ? coef_q[k] : '0;
      pmc_cell #(
        .COEF_WIDTH(COEF_WIDTH),
        .ACC_W     (SUM_W)
      ) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctrl_i(ctrl),
        .coef_i(coef_eff[k]),
        .x_i   (x_in),
        .sum_i (ps[k + 1]),
        .acc_o (ps[k])
      );
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_TD_W - OUT_W){1'b0}}, y_q};

  // tail counter stays within the largest degree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_cnt_q <= DEG_W'(MAX_DEGREE))
    else $error("tail counter out of range");

  // the running sum behind the output cell is zero after the final result of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> ps[1] == '0)
    else $error("running sums not cleared at end of frame");

  // a stalled result keeps its flag and stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_last_q) && $stable(y_q))
    else $error("stalled result changed");

  // no new product while the held one is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_take |-> !ctrl.load)
    else $error("product stage overwritten");

endmodule
